FILE: src/bsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg: types and constants of the barometric sensor compensation
// Holds the sample and result item layouts and the register map.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // Raw sample item
  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } sample_t;

  // Compensated result item
  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic signed [31:0] fine_temperature;
    logic               divide_error;
  } result_t;

  // Register indexes (byte address / 8)
  typedef enum logic [1:0] {
    REG_TEMP_CAL   = 2'd0,
    REG_PRESS_LOW  = 2'd1,
    REG_PRESS_HIGH = 2'd2,
    REG_PRESS_LAST = 2'd3
  } reg_idx_t;

  localparam int DIV_BITS = 32;

  localparam logic [31:0] FINE_OFFSET  = 32'd64000;
  localparam logic [31:0] P_FULL_SCALE = 32'd1048576;
  localparam logic [31:0] P_SCALE      = 32'd3125;
  localparam logic [31:0] P1_OFFSET    = 32'd32768;
  localparam logic [31:0] T_ROUND      = 32'd128;

  // Data carried alongside the divider
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic        err;
    logic        dbl;
  } side_t;

endpackage
`default_nettype wire

FILE: src/baro_sensor_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baro_sensor_compensation: 32-bit integer temperature/pressure compensation
// Fully pipelined; one raw sample pair per clock, one result per sample.
// ----------------------------------------------------------------------------
// A sample item is taken on every cycle with start high (busy stays low, the
// pipeline never stalls). Its result appears on result for exactly one
// cycle with valid high; the receiver must take it then. Between sample
// and result lie nine arithmetic stages ahead of the divider, one divider
// load stage, the 32-stage radix-2 pressure divider (one quotient bit per
// stage) and four stages of final pressure correction and output. The
// user must write calibration over the APB port (registers at byte address
// 8*i) only while no item is in flight; the block does not enforce this.
module baro_sensor_compensation
  import bsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire sample_t     sample,
  output logic             valid,
  output result_t          result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int LATENCY = 14 + DIV_BITS;

  function automatic logic [31:0] sra(input logic [31:0] v, input int unsigned s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Calibration registers
  logic [47:0] temp_cal;
  logic [63:0] press_cal_low;
  logic [63:0] press_cal_high;
  logic [15:0] press_cal_last;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write a calibration register
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal       <= '0;
      press_cal_low  <= '0;
      press_cal_high <= '0;
      press_cal_last <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TEMP_CAL:   temp_cal       <= pwdata[47:0];
        REG_PRESS_LOW:  press_cal_low  <= pwdata;
        REG_PRESS_HIGH: press_cal_high <= pwdata;
        REG_PRESS_LAST: press_cal_last <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back a calibration register
  always_comb begin
    case (cfg_idx)
      REG_TEMP_CAL:   prdata = {16'd0, temp_cal};
      REG_PRESS_LOW:  prdata = press_cal_low;
      REG_PRESS_HIGH: prdata = press_cal_high;
      REG_PRESS_LAST: prdata = {48'd0, press_cal_last};
      default:        prdata = '0;
    endcase
  end

  // Coefficients as 32-bit words
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, temp_cal[15:0]};
  assign t2 = sx16(temp_cal[31:16]);
  assign t3 = sx16(temp_cal[47:32]);
  assign p1 = {16'd0, press_cal_low[15:0]};
  assign p2 = sx16(press_cal_low[31:16]);
  assign p3 = sx16(press_cal_low[47:32]);
  assign p4 = sx16(press_cal_low[63:48]);
  assign p5 = sx16(press_cal_high[15:0]);
  assign p6 = sx16(press_cal_high[31:16]);
  assign p7 = sx16(press_cal_high[47:32]);
  assign p8 = sx16(press_cal_high[63:48]);
  assign p9 = sx16(press_cal_last);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid bits of the front stages
  logic [9:1] fv;

  logic [19:0] s1_adcp, s2_adcp, s3_adcp, s4_adcp, s5_adcp, s6_adcp, s7_adcp, s8_adcp;
  logic [31:0] s1_m1, s1_dd, s2_at, s2_m2, s3_fine;
  logic [31:0] s4_temp, s4_fine, s4_pa;
  logic [31:0] s5_temp, s5_fine, s5_q, s5_ap5, s5_ap2;
  logic [31:0] s6_temp, s6_fine, s6_b1, s6_q3, s6_ap5, s6_ap2;
  logic [31:0] s7_temp, s7_fine, s7_b, s7_a;
  logic [31:0] s8_temp, s8_fine, s8_b, s8_ap1;
  logic [31:0] s9_temp, s9_fine, s9_a, s9_pn;
  logic [31:0] x1, dt;

  assign x1 = {15'd0, sample.raw_temperature[19:3]} - (t1 << 1);
  assign dt = {16'd0, sample.raw_temperature[19:4]} - t1;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else begin
      fv <= {fv[8:1], accept};
    end
  end

  // Temperature and pressure coefficient stages
  always_ff @(posedge clk) begin
    s1_adcp <= sample.raw_pressure;
    s1_m1   <= x1 * t2;
    s1_dd   <= dt * dt;

    s2_adcp <= s1_adcp;
    s2_at   <= sra(s1_m1, 11);
    s2_m2   <= sra(s1_dd, 12) * t3;

    s3_adcp <= s2_adcp;
    s3_fine <= s2_at + sra(s2_m2, 14);

    s4_adcp <= s3_adcp;
    s4_fine <= s3_fine;
    s4_temp <= sra((s3_fine << 2) + s3_fine + T_ROUND, 8);
    s4_pa   <= sra(s3_fine, 1) - FINE_OFFSET;

    s5_adcp <= s4_adcp;
    s5_temp <= s4_temp;
    s5_fine <= s4_fine;
    s5_q    <= sra(s4_pa, 2) * sra(s4_pa, 2);
    s5_ap5  <= s4_pa * p5;
    s5_ap2  <= p2 * s4_pa;

    s6_adcp <= s5_adcp;
    s6_temp <= s5_temp;
    s6_fine <= s5_fine;
    s6_b1   <= sra(s5_q, 11) * p6;
    s6_q3   <= p3 * sra(s5_q, 13);
    s6_ap5  <= s5_ap5;
    s6_ap2  <= s5_ap2;

    s7_adcp <= s6_adcp;
    s7_temp <= s6_temp;
    s7_fine <= s6_fine;
    s7_b    <= sra(s6_b1 + (s6_ap5 << 1), 2) + (p4 << 16);
    s7_a    <= sra(sra(s6_q3, 3) + sra(s6_ap2, 1), 18);

    s8_adcp <= s7_adcp;
    s8_temp <= s7_temp;
    s8_fine <= s7_fine;
    s8_b    <= s7_b;
    s8_ap1  <= (P1_OFFSET + s7_a) * p1;

    s9_temp <= s8_temp;
    s9_fine <= s8_fine;
    s9_a    <= sra(s8_ap1, 15);
    s9_pn   <= ((P_FULL_SCALE - {12'd0, s8_adcp}) - sra(s8_b, 12)) * P_SCALE;
  end

  // Divider pipeline: entry 0 is the load stage, one quotient bit per stage
  logic [DIV_BITS:0] dv;
  logic [31:0]       d_rem [DIV_BITS+1];
  logic [31:0]       d_quo [DIV_BITS+1];
  logic [31:0]       d_div [DIV_BITS+1];
  side_t             d_side [DIV_BITS+1];

  // Load the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= fv[9];
    end
    d_rem[0]       <= '0;
    d_quo[0]       <= s9_pn[31] ? s9_pn : (s9_pn << 1);
    d_div[0]       <= s9_a;
    d_side[0].temp <= s9_temp;
    d_side[0].fine <= s9_fine;
    d_side[0].err  <= (s9_a == '0);
    d_side[0].dbl  <= s9_pn[31];
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    logic [32:0] trial;
    logic        fits;
    assign trial = {d_rem[k], d_quo[k][31]};
    assign fits  = trial >= {1'b0, d_div[k]};

    // Shift in one dividend bit, subtract when it fits
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
      d_rem[k+1]  <= fits ? 32'(trial - {1'b0, d_div[k]}) : trial[31:0];
      d_quo[k+1]  <= {d_quo[k][30:0], fits};
      d_div[k+1]  <= d_div[k];
      d_side[k+1] <= d_side[k];
    end
  end

  // Final pressure correction stages
  logic [3:1]  ev;
  side_t       e1_side, e2_side, e3_side;
  logic [31:0] e1_p, e2_p, e2_pp, e2_pb, e3_p, e3_m9, e3_pbs;
  logic [31:0] e1_p3;

  assign e1_p3 = {3'd0, e1_p[31:3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      ev    <= '0;
      valid <= 1'b0;
    end else begin
      ev    <= {ev[2:1], dv[DIV_BITS]};
      valid <= ev[3];
    end
  end

  always_ff @(posedge clk) begin
    e1_side <= d_side[DIV_BITS];
    e1_p    <= d_side[DIV_BITS].dbl ? (d_quo[DIV_BITS] << 1) : d_quo[DIV_BITS];

    e2_side <= e1_side;
    e2_p    <= e1_p;
    e2_pp   <= e1_p3 * e1_p3;
    e2_pb   <= {2'd0, e1_p[31:2]} * p8;

    e3_side <= e2_side;
    e3_p    <= e2_p;
    e3_m9   <= p9 * (e2_pp >> 13);
    e3_pbs  <= sra(e2_pb, 13);

    result.temperature_centi <= e3_side.temp;
    result.fine_temperature  <= e3_side.fine;
    result.divide_error      <= e3_side.err;
    result.pressure_pa       <= e3_side.err ? '0 :
                                e3_p + sra(sra(e3_m9, 12) + e3_pbs + p7, 4);
  end

  // A zero divisor always gives zero pressure
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    valid && result.divide_error |-> result.pressure_pa == '0)
    else $error("pressure not zero on divide error");

  // Error flag at divider load matches the divisor
  a_err_load: assert property (@(posedge clk) disable iff (rst)
    dv[0] |-> d_side[0].err == (d_div[0] == '0))
    else $error("divide error flag mismatch");

  // The valid strobe follows each accepted item through the whole pipeline
  a_latency: assert property (@(posedge clk)
    !rst && $past(!rst, LATENCY) |-> valid == $past(accept, LATENCY))
    else $error("result strobe out of step with accepted items");

endmodule
`default_nettype wire
